/* rtl/nsbh_pkg.sv */
// Package for the nearest segment/box hit block: sequencer states and field widths.
// No dependencies.
package nsbh_pkg;
    localparam int COORD_W = 24;
    localparam int SIZE_W  = 23;
    localparam int IDX_W   = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_DIV,
        ST_PT,
        ST_MUL,
        ST_UPD
    } nsbh_state_t;

    // request from sequencer to the divider
    typedef struct packed {
        logic start;
        logic neg;
    } nsbh_div_ctl_t;
endpackage

/* rtl/nsbh_div.sv */
// Restoring bit-serial divider: one quotient bit per cycle, floor semantics.
// Depends on nsbh_pkg.
module nsbh_div
    import nsbh_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 26
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nsbh_div_ctl_t        ctl,
    input  logic [NW-1:0]        num,     // magnitude of dividend
    input  logic [DW-1:0]        den,     // positive divisor
    output logic                 done,
    output logic [NW-1:0]        quo,     // floor quotient magnitude
    output logic                 rem_nz
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   r_sh;
    logic [DW+1:0] r_sub;

    assign r_sh  = {r_reg[DW-1:0], q_reg[NW-1]};
    assign r_sub = {1'b0, r_sh} - {2'b0, d_reg};

    // shift-subtract loop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctl.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
            q_reg    <= num;
            r_reg    <= '0;
            d_reg    <= den;
        end else if (busy_reg) begin
            if (!r_sub[DW+1]) begin
                r_reg <= r_sub[DW:0];
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end else begin
                r_reg <= r_sh;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_reg <= 1'b0;
        end
    end
    assign done   = busy_reg && cnt_reg == '0 ? 1'b0 : (!busy_reg);
    assign quo    = q_reg;
    assign rem_nz = |r_reg;
endmodule

/* rtl/nearest_segment_box_hit.sv */
// Per request: a test per box edge, each a serial divide unless the segment is parallel to
// the edge, then a set-up step, two serial multiplies and an update; a failed test skips
// the rest. One request is taken at a time, only in idle; an inactive box skips to update.
// A result waits in the output register while the next run is processed; only the update
// of the next last box stalls on it. Reset: aresetn synchronous active low clears run state.
// Depends on nsbh_pkg and nsbh_div.
module nearest_segment_box_hit
    import nsbh_pkg::*;
#(
    parameter int MAX_BOXES   = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, box_left, box_top, box_width,
    // box_height, box_active (bits 0..190), zero pad to 192
    input  logic [191:0] s_tdata,
    input  logic         s_tlast,     // last_box
    output logic         m_tvalid,
    input  logic         m_tready,
    // any_hit, hit_index, hit_x, hit_y, hit_t (bits 0..69), zero pad to 72
    output logic [71:0]  m_tdata
);
    localparam int TW  = T_FRAC_BITS + 1;
    localparam int NW  = 27 + T_FRAC_BITS;     // |q|*ONE magnitude
    localparam int DW  = 26;
    localparam int PW  = 26 + TW;              // product width
    localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;
    localparam int CNT_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [CNT_W-1:0] IDX_TOP = CNT_W'(MAX_BOXES - 1);
    localparam int MCW = $clog2(TW + 1);

    nsbh_state_t st_reg, st_next;
    logic signed [25:0] ax_reg, ay_reg, dx_reg, dy_reg;
    logic signed [25:0] left_reg, top_reg, right_reg, bot_reg;
    logic act_reg, last_reg;
    logic [1:0] edge_reg;
    logic signed [TW+1:0] t0_reg, t1_reg;   // range -1 .. ONE+1
    logic ok_reg, pneg_reg;
    logic axis_reg;
    logic [TW-1:0]  best_t_reg;
    logic signed [23:0] best_x_reg, best_y_reg, px_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [CNT_W-1:0] cnt_reg, idx_reg;
    logic found_reg;
    logic [71:0] out_reg;
    logic ovalid_reg;
    // serial multiplier
    logic signed [PW:0] acc_reg;
    logic [TW-1:0] mq_reg;
    logic [MCW-1:0] mc_reg;

    // current edge terms
    logic signed [25:0] p_cur, q_cur;
    always_comb begin
        case (edge_reg)
            2'd0: begin p_cur = -dx_reg; q_cur = ax_reg - left_reg; end
            2'd1: begin p_cur = dx_reg;  q_cur = right_reg - ax_reg; end
            2'd2: begin p_cur = -dy_reg; q_cur = ay_reg - top_reg; end
            default: begin p_cur = dy_reg; q_cur = bot_reg - ay_reg; end
        endcase
    end

    // sign moved onto positive divisor
    logic signed [26:0] qn;
    logic [DW-1:0] pmag;
    logic neg_num;
    assign qn      = p_cur[25] ? -{q_cur[25], q_cur} : {q_cur[25], q_cur};
    assign pmag    = p_cur[25] ? DW'(-p_cur) : DW'(p_cur);
    assign neg_num = qn[26];
    logic [26:0] qmag;
    assign qmag = neg_num ? 27'(-qn) : 27'(qn);

    nsbh_div_ctl_t dctl;
    logic div_done, rem_nz;
    logic [NW-1:0] quo;
    logic [NW-1:0] dnum;
    assign dnum = {qmag, {T_FRAC_BITS{1'b0}}};
    assign dctl.start = (st_reg == ST_EDGE) && (p_cur != '0);
    assign dctl.neg   = neg_num;

    nsbh_div #(.NW(NW), .DW(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(dctl), .num(dnum), .den(pmag),
        .done(div_done), .quo(quo), .rem_nz(rem_nz));

    // saturated signed quotient
    logic neg_reg_q;
    logic signed [TW+1:0] tq;
    always_comb begin
        if (neg_reg_q) tq = (quo != '0 || rem_nz) ? -(TW+2)'(1) : '0;
        else if (quo > NW'(T_ONE) + NW'(1)) tq = (TW+2)'(T_ONE) + 1'b1;
        else tq = (TW+2)'(quo);
    end
    always_ff @(posedge aclk) if (dctl.start) neg_reg_q <= dctl.neg;

    logic div_wait_reg;
    logic ok_edge;
    logic signed [TW+1:0] t0_n, t1_n;
    always_comb begin
        ok_edge = 1'b1; t0_n = t0_reg; t1_n = t1_reg;
        if (pneg_reg) begin
            if (tq > t1_reg) ok_edge = 1'b0;
            else if (tq > t0_reg) t0_n = tq;
        end else begin
            if (tq < t0_reg) ok_edge = 1'b0;
            else if (tq < t1_reg) t1_n = tq;
        end
    end

    logic s_fire, m_fire;
    logic upd_go;
    assign s_tready = (st_reg == ST_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = ovalid_reg && m_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;
    // a last box waits in update until the output register is free
    assign upd_go = !last_reg || !ovalid_reg || m_tready;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (s_fire) st_next = s_tdata[190] ? ST_EDGE : ST_UPD;
            ST_EDGE: st_next = (p_cur != '0) ? ST_DIV :
                ((q_cur[25] || edge_reg == 2'd3) ? ST_PT : ST_EDGE);
            ST_DIV:  if (div_wait_reg && div_done)
                st_next = (!ok_edge || edge_reg == 2'd3) ? ST_PT : ST_EDGE;
            ST_PT:   st_next = ok_reg ? ST_MUL : ST_UPD;
            ST_MUL:  if (mc_reg == '0 && axis_reg) st_next = ST_UPD;
            ST_UPD:  if (upd_go) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // entry point rounding
    logic signed [PW:0] rnd;
    logic signed [PW:0] shf;
    logic signed [PW+1:0] pt;
    assign rnd = acc_reg + (PW+1)'(T_ONE >> 1);
    assign shf = rnd >>> T_FRAC_BITS;
    assign pt  = (PW+2)'(axis_reg ? ay_reg : ax_reg) + (PW+2)'(shf);
    logic signed [23:0] pt_sat;
    assign pt_sat = (pt > (PW+2)'(8388607)) ? 24'sh7FFFFF :
                    (pt < -(PW+2)'(8388608)) ? 24'sh800000 : pt[23:0];

    logic better;
    assign better = ok_reg && act_reg && (!found_reg || TW'(t0_reg) < best_t_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; ovalid_reg <= 1'b0; found_reg <= 1'b0;
            cnt_reg <= '0; best_t_reg <= T_ONE + 1'b1; div_wait_reg <= 1'b0;
            best_x_reg <= '0; best_y_reg <= '0; best_idx_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_UPD && last_reg && upd_go) ovalid_reg <= 1'b1;
            else if (m_fire) ovalid_reg <= 1'b0;
            div_wait_reg <= dctl.start ? 1'b1 : (div_done ? 1'b0 : div_wait_reg);
            case (st_reg)
                ST_IDLE: if (s_fire) begin
                    ax_reg <= 26'($signed(s_tdata[23:0]));
                    ay_reg <= 26'($signed(s_tdata[47:24]));
                    dx_reg <= 26'($signed(s_tdata[71:48])) - 26'($signed(s_tdata[23:0]));
                    dy_reg <= 26'($signed(s_tdata[95:72])) - 26'($signed(s_tdata[47:24]));
                    left_reg  <= 26'($signed(s_tdata[119:96]));
                    top_reg   <= 26'($signed(s_tdata[143:120]));
                    right_reg <= 26'($signed(s_tdata[119:96])) + 26'(s_tdata[166:144]);
                    bot_reg   <= 26'($signed(s_tdata[143:120])) + 26'(s_tdata[189:167] & 23'h7FFFFF);
                    act_reg <= s_tdata[190]; last_reg <= s_tlast;
                    edge_reg <= 2'd0; ok_reg <= 1'b1;
                    t0_reg <= '0; t1_reg <= (TW+2)'(T_ONE);
                    idx_reg <= cnt_reg;
                    if (cnt_reg < IDX_TOP) cnt_reg <= cnt_reg + 1'b1;
                end
                ST_EDGE: begin
                    pneg_reg <= p_cur[25];
                    if (p_cur == '0) begin
                        if (q_cur[25]) ok_reg <= 1'b0;
                        edge_reg <= edge_reg + 1'b1;
                    end
                end
                ST_DIV: if (div_wait_reg && div_done) begin
                    ok_reg <= ok_edge; t0_reg <= t0_n; t1_reg <= t1_n;
                    edge_reg <= edge_reg + 1'b1;
                end
                ST_PT: begin
                    axis_reg <= 1'b0; acc_reg <= '0;
                    mq_reg <= TW'(t0_reg); mc_reg <= MCW'(TW);
                end
                ST_MUL: begin
                    if (mc_reg != '0) begin
                        acc_reg <= (acc_reg <<< 1) + (mq_reg[TW-1] ?
                            (PW+1)'(axis_reg ? dy_reg : dx_reg) : '0);
                        mq_reg <= mq_reg << 1;
                        mc_reg <= mc_reg - 1'b1;
                    end else if (!axis_reg) begin
                        px_reg <= pt_sat; axis_reg <= 1'b1; acc_reg <= '0;
                        mq_reg <= TW'(t0_reg); mc_reg <= MCW'(TW);
                    end
                end
                ST_UPD: if (upd_go) begin
                    logic [IDX_W-1:0] bi;
                    logic [TW-1:0] bt;
                    logic signed [23:0] bx, by;
                    logic bf;
                    bi = best_idx_reg; bt = best_t_reg; bx = best_x_reg;
                    by = best_y_reg; bf = found_reg;
                    if (better) begin
                        bi = IDX_W'(idx_reg); bt = TW'(t0_reg); bx = px_reg; by = pt_sat;
                        bf = 1'b1;
                    end
                    if (last_reg) begin
                        out_reg <= bf ? {2'b0, 17'(bt), by, bx, bi, 1'b1} : '0;
                        found_reg <= 1'b0; cnt_reg <= '0; best_t_reg <= T_ONE + 1'b1;
                        best_idx_reg <= '0; best_x_reg <= '0; best_y_reg <= '0;
                    end else begin
                        best_idx_reg <= bi; best_t_reg <= bt; best_x_reg <= bx;
                        best_y_reg <= by; found_reg <= bf;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> st_reg == ST_IDLE) else $error("ready outside idle");
    a_t_order: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_PT && ok_reg |-> t0_reg <= t1_reg) else $error("t0 above t1");
    a_cnt_top: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= IDX_TOP) else $error("counter past top");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while waiting");
`endif
endmodule
